/* rtl/chbd_pkg.sv */
// Package for the canonical Huffman bit decoder.
// Holds the sizes, opcode and register index codes, and the structs shared by the modules.
// It depends on nothing.
package chbd_pkg;

    localparam int NUM_SYMBOLS     = 257;
    localparam int MAX_CODE_LENGTH = 32;
    localparam int SYM_W           = $clog2(NUM_SYMBOLS);
    localparam int LEN_W           = 6;
    localparam int CODE_W          = 32;
    localparam int OUT_SYM_W       = 8;
    localparam int BYTE_W          = 8;
    localparam int BIT_CNT_W       = 3;
    localparam int OP_W            = 2;
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 6;
    localparam int LEN_SLOTS       = MAX_CODE_LENGTH + 1;

    localparam logic [SYM_W-1:0] END_SYMBOL = SYM_W'(NUM_SYMBOLS - 1);

    localparam logic [OP_W-1:0] OP_DECODE    = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_SYMBOL = 2'd1;
    localparam logic [OP_W-1:0] OP_WR_LENGTH = 2'd2;
    localparam logic [OP_W-1:0] OP_RESTART   = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LEN = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LEN = 1'd1;

    // Write port of the symbol table and of the per-length tables.
    typedef struct packed {
        logic              sym_we;
        logic [SYM_W-1:0]  sym_addr;
        logic [SYM_W-1:0]  sym_data;
        logic              len_we;
        logic [LEN_W-1:0]  len_addr;
        logic [SYM_W-1:0]  start_data;
        logic [CODE_W-1:0] first_data;
    } tbl_wr_t;

    // Verdict of the code compare unit for the current code value and length.
    typedef struct packed {
        logic             hit;
        logic             at_max;
        logic             pos_ok;
        logic [SYM_W-1:0] pos;
    } match_t;

endpackage

/* rtl/chbd_tables.sv */
// Symbol table and per-length start index and first code tables.
// All reads are registered; uses chbd_pkg for sizes and the write struct.
module chbd_tables
(
    input  logic                           clk,
    input  chbd_pkg::tbl_wr_t              wr,
    input  logic                           len_rd_en,
    input  logic [chbd_pkg::LEN_W-1:0]     len_rd_addr,
    output logic [chbd_pkg::SYM_W-1:0]     start_rd,
    output logic [chbd_pkg::CODE_W-1:0]    first_rd,
    input  logic                           sym_rd_en,
    input  logic [chbd_pkg::SYM_W-1:0]     sym_rd_addr,
    output logic [chbd_pkg::SYM_W-1:0]     sym_rd
);

    logic [chbd_pkg::SYM_W-1:0]  sym_mem   [0:chbd_pkg::NUM_SYMBOLS-1];
    logic [chbd_pkg::SYM_W-1:0]  start_mem [0:chbd_pkg::LEN_SLOTS-1];
    logic [chbd_pkg::CODE_W-1:0] first_mem [0:chbd_pkg::LEN_SLOTS-1];

    always_ff @(posedge clk)
    begin
        if (wr.sym_we)
        begin
            sym_mem[wr.sym_addr] <= wr.sym_data;
        end
        if (sym_rd_en)
        begin
            sym_rd <= sym_mem[sym_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.len_we)
        begin
            start_mem[wr.len_addr] <= wr.start_data;
            first_mem[wr.len_addr] <= wr.first_data;
        end
        if (len_rd_en)
        begin
            start_rd <= start_mem[len_rd_addr];
            first_rd <= first_mem[len_rd_addr];
        end
    end

endmodule

/* rtl/chbd_match.sv */
// Shared code compare unit: the range compares and one subtract-add per decoded bit.
// Uses chbd_pkg for widths and the verdict struct.
module chbd_match
(
    input  logic [chbd_pkg::CODE_W-1:0] code_value,
    input  logic [chbd_pkg::LEN_W-1:0]  code_length,
    input  logic [chbd_pkg::LEN_W-1:0]  min_len,
    input  logic [chbd_pkg::LEN_W-1:0]  max_len,
    input  logic [chbd_pkg::CODE_W-1:0] first_code,
    input  logic [chbd_pkg::SYM_W-1:0]  start_index,
    output chbd_pkg::match_t            verdict
);

    localparam int POS_W = chbd_pkg::CODE_W + 1;

    logic [chbd_pkg::CODE_W-1:0] diff;
    logic [POS_W-1:0]            pos_full;

    always_comb
    begin
        diff     = code_value - first_code;
        pos_full = POS_W'(start_index) + POS_W'(diff);

        verdict.hit    = (code_length >= min_len) && (code_length <= max_len) &&
                         (code_value >= first_code);
        verdict.at_max = (code_length >= max_len);
        verdict.pos_ok = (pos_full < POS_W'(chbd_pkg::NUM_SYMBOLS));
        verdict.pos    = pos_full[chbd_pkg::SYM_W-1:0];
    end

endmodule

/* rtl/canonical_huffman_bit_decoder.sv */
// Top level of the canonical Huffman bit decoder: sequencer, registers and output stage.
// Depends on chbd_pkg, chbd_tables and chbd_match.
//
// Usage: items arrive on the item channel (item_valid/item_ready). Opcode OP_WR_SYMBOL
// loads one symbol table entry, OP_WR_LENGTH loads the start index and first code of
// one code length, OP_RESTART clears the running code and the end-of-stream flag, and
// OP_DECODE brings one compressed byte whose bits are decoded most significant first.
// Table, restart and ignored decode transactions complete in S_IDLE. A decode byte is
// walked one bit at a time through a shared compare unit: a bit with no match passes
// S_SHIFT (shift and table read) and S_CHECK (compare), a bit that ends an over-long or
// out-of-range code adds S_PUSH, and a bit that yields a symbol adds S_LOOKUP (symbol
// table read) and S_PUSH (result hand-off); S_FLUSH closes the byte. The registered
// table reads are why reads and compares sit in separate states. item_ready is high
// only while the sequencer is idle.
// Results leave on the result channel (result_valid/result_ready) through an output
// register. Each result is held in a pending slot until the next one shows up or the
// byte ends, so that last_of_run can mark the final result of the byte. When the
// receiver stalls, the sequencer waits at the hand-off and resumes when the slot frees.
// Configuration writes (cfg_valid/cfg_ready) are always taken and are meant for idle
// periods. Reset clears the code state, the flags and the registers (min length 1,
// max length 32); the tables hold undefined data until loaded.
module canonical_huffman_bit_decoder
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [chbd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [chbd_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic [chbd_pkg::OP_W-1:0]           opcode,
    input  logic [chbd_pkg::BYTE_W-1:0]         data_byte,
    input  logic [chbd_pkg::SYM_W-1:0]          table_index,
    input  logic [chbd_pkg::SYM_W-1:0]          entry_symbol,
    input  logic [chbd_pkg::SYM_W-1:0]          entry_start,
    input  logic [chbd_pkg::CODE_W-1:0]         entry_first_code,

    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [chbd_pkg::OUT_SYM_W-1:0]      symbol,
    output logic                                end_seen,
    output logic                                code_error,
    output logic                                last_of_run
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SHIFT  = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_LOOKUP = 3'd3;
    localparam logic [2:0] S_PUSH   = 3'd4;
    localparam logic [2:0] S_FLUSH  = 3'd5;

    localparam int LEN_W  = chbd_pkg::LEN_W;
    localparam int SYM_W  = chbd_pkg::SYM_W;
    localparam int CODE_W = chbd_pkg::CODE_W;
    localparam int OSYM_W = chbd_pkg::OUT_SYM_W;

    logic [2:0]                         state_reg, state_next;
    logic [chbd_pkg::BYTE_W-1:0]        byte_reg, byte_next;
    logic [chbd_pkg::BIT_CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [CODE_W-1:0]                  value_reg, value_next;
    logic [LEN_W-1:0]                   len_reg, len_next;
    logic                               finished_reg, finished_next;
    logic [LEN_W-1:0]                   min_reg, min_next;
    logic [LEN_W-1:0]                   max_reg, max_next;

    // Newest result, and the pending one that waits to learn whether it ends the byte.
    logic [OSYM_W-1:0]                  res_sym_reg, res_sym_next;
    logic                               res_end_reg, res_end_next;
    logic                               res_err_reg, res_err_next;
    logic                               pend_valid_reg, pend_valid_next;
    logic [OSYM_W-1:0]                  pend_sym_reg, pend_sym_next;
    logic                               pend_end_reg, pend_end_next;
    logic                               pend_err_reg, pend_err_next;

    // Output register.
    logic                               out_valid_reg, out_valid_next;
    logic [OSYM_W-1:0]                  out_sym_reg, out_sym_next;
    logic                               out_end_reg, out_end_next;
    logic                               out_err_reg, out_err_next;
    logic                               out_last_reg, out_last_next;

    chbd_pkg::tbl_wr_t                  tbl_wr;
    logic                               len_rd_en;
    logic [LEN_W-1:0]                   len_rd_addr;
    logic [SYM_W-1:0]                   start_rd;
    logic [CODE_W-1:0]                  first_rd;
    logic                               sym_rd_en;
    logic [SYM_W-1:0]                   sym_rd;
    chbd_pkg::match_t                   verdict;

    logic [LEN_W-1:0]                   min_eff;
    logic [LEN_W-1:0]                   max_eff;
    logic                               item_fire;
    logic                               out_free;
    logic                               last_bit;

    chbd_tables u_tables
    (
        .clk         (clk),
        .wr          (tbl_wr),
        .len_rd_en   (len_rd_en),
        .len_rd_addr (len_rd_addr),
        .start_rd    (start_rd),
        .first_rd    (first_rd),
        .sym_rd_en   (sym_rd_en),
        .sym_rd_addr (verdict.pos),
        .sym_rd      (sym_rd)
    );

    chbd_match u_match
    (
        .code_value  (value_reg),
        .code_length (len_reg),
        .min_len     (min_eff),
        .max_len     (max_eff),
        .first_code  (first_rd),
        .start_index (start_rd),
        .verdict     (verdict)
    );

    // A minimum of zero acts as one; the maximum is clipped to 1..MAX_CODE_LENGTH.
    always_comb
    begin
        min_eff = (min_reg == '0) ? LEN_W'(1) : min_reg;
        if (max_reg == '0)
        begin
            max_eff = LEN_W'(1);
        end
        else if (max_reg > LEN_W'(chbd_pkg::MAX_CODE_LENGTH))
        begin
            max_eff = LEN_W'(chbd_pkg::MAX_CODE_LENGTH);
        end
        else
        begin
            max_eff = max_reg;
        end
    end

    assign cfg_ready    = 1'b1;
    assign item_ready   = (state_reg == S_IDLE);
    assign item_fire    = item_valid && item_ready;
    assign out_free     = !out_valid_reg || result_ready;
    assign last_bit     = (bit_cnt_reg == '0);

    assign result_valid = out_valid_reg;
    assign symbol       = out_sym_reg;
    assign end_seen     = out_end_reg;
    assign code_error   = out_err_reg;
    assign last_of_run  = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        byte_next       = byte_reg;
        bit_cnt_next    = bit_cnt_reg;
        value_next      = value_reg;
        len_next        = len_reg;
        finished_next   = finished_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        res_sym_next    = res_sym_reg;
        res_end_next    = res_end_reg;
        res_err_next    = res_err_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        pend_end_next   = pend_end_reg;
        pend_err_next   = pend_err_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        out_sym_next    = out_sym_reg;
        out_end_next    = out_end_reg;
        out_err_next    = out_err_reg;
        out_last_next   = out_last_reg;

        tbl_wr.sym_we     = 1'b0;
        tbl_wr.sym_addr   = table_index;
        tbl_wr.sym_data   = entry_symbol;
        tbl_wr.len_we     = 1'b0;
        tbl_wr.len_addr   = table_index[LEN_W-1:0];
        tbl_wr.start_data = entry_start;
        tbl_wr.first_data = entry_first_code;
        len_rd_en         = 1'b0;
        len_rd_addr       = len_reg + LEN_W'(1);
        sym_rd_en         = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                chbd_pkg::CFG_MIN_LEN: min_next = cfg_data;
                chbd_pkg::CFG_MAX_LEN: max_next = cfg_data;
                default:               min_next = min_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_fire)
                begin
                    unique case (opcode)
                        chbd_pkg::OP_WR_SYMBOL:
                        begin
                            tbl_wr.sym_we = (table_index < SYM_W'(chbd_pkg::NUM_SYMBOLS));
                        end
                        chbd_pkg::OP_WR_LENGTH:
                        begin
                            tbl_wr.len_we = (table_index != '0) &&
                                (table_index <= SYM_W'(chbd_pkg::MAX_CODE_LENGTH));
                        end
                        chbd_pkg::OP_RESTART:
                        begin
                            value_next    = '0;
                            len_next      = '0;
                            finished_next = 1'b0;
                        end
                        chbd_pkg::OP_DECODE:
                        begin
                            if (!finished_reg)
                            begin
                                byte_next    = data_byte;
                                bit_cnt_next = '1;
                                state_next   = S_SHIFT;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Shift the next bit in and read the tables for the new length.
            S_SHIFT:
            begin
                value_next  = {value_reg[CODE_W-2:0], byte_reg[bit_cnt_reg]};
                len_next    = len_reg + LEN_W'(1);
                len_rd_en   = 1'b1;
                state_next  = S_CHECK;
            end

            S_CHECK:
            begin
                if (verdict.hit)
                begin
                    value_next = '0;
                    len_next   = '0;
                    if (verdict.pos_ok)
                    begin
                        sym_rd_en  = 1'b1;
                        state_next = S_LOOKUP;
                    end
                    else
                    begin
                        res_sym_next = '0;
                        res_end_next = 1'b0;
                        res_err_next = 1'b1;
                        state_next   = S_PUSH;
                    end
                end
                else if (verdict.at_max)
                begin
                    value_next   = '0;
                    len_next     = '0;
                    res_sym_next = '0;
                    res_end_next = 1'b0;
                    res_err_next = 1'b1;
                    state_next   = S_PUSH;
                end
                else if (last_bit)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                    state_next   = S_SHIFT;
                end
            end

            S_LOOKUP:
            begin
                res_err_next = 1'b0;
                if (sym_rd == chbd_pkg::END_SYMBOL)
                begin
                    res_sym_next  = '0;
                    res_end_next  = 1'b1;
                    finished_next = 1'b1;
                end
                else
                begin
                    res_sym_next = sym_rd[OSYM_W-1:0];
                    res_end_next = 1'b0;
                end
                state_next = S_PUSH;
            end

            // Retire the older pending result, then park the new one.
            S_PUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_sym_next   = pend_sym_reg;
                        out_end_next   = pend_end_reg;
                        out_err_next   = pend_err_reg;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_sym_next   = res_sym_reg;
                    pend_end_next   = res_end_reg;
                    pend_err_next   = res_err_reg;
                    if (res_end_reg || last_bit)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        bit_cnt_next = bit_cnt_reg - 1'b1;
                        state_next   = S_SHIFT;
                    end
                end
            end

            // The byte is done: the pending result, if any, is its last.
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sym_next    = pend_sym_reg;
                    out_end_next    = pend_end_reg;
                    out_err_next    = pend_err_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            value_reg      <= '0;
            len_reg        <= '0;
            finished_reg   <= 1'b0;
            min_reg        <= LEN_W'(1);
            max_reg        <= LEN_W'(chbd_pkg::MAX_CODE_LENGTH);
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            bit_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            value_reg      <= value_next;
            len_reg        <= len_next;
            finished_reg   <= finished_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            bit_cnt_reg    <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        res_sym_reg  <= res_sym_next;
        res_end_reg  <= res_end_next;
        res_err_reg  <= res_err_next;
        pend_sym_reg <= pend_sym_next;
        pend_end_reg <= pend_end_next;
        pend_err_reg <= pend_err_next;
        out_sym_reg  <= out_sym_next;
        out_end_reg  <= out_end_next;
        out_err_reg  <= out_err_next;
        out_last_reg <= out_last_next;
    end

endmodule
